// ----- rtl/core/fce_pkg.sv -----
// Shared types and constants for the pipe-to-CSV field escaper.
// Holds byte codes, sequencer state and kind enums, and the emit struct.
// No dependencies.
package fce_pkg;

	// Default buffer depth in bytes
	localparam int FIELD_BYTES_DEF = 28;

	// Byte codes
	localparam logic [7:0] BYTE_PIPE    = 8'd124;
	localparam logic [7:0] BYTE_NEWLINE = 8'd10;
	localparam logic [7:0] BYTE_QUOTE   = 8'd34;
	localparam logic [7:0] BYTE_COMMA   = 8'd44;
	localparam logic [7:0] BYTE_SPACE   = 8'd32;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEP_COMMA,
		ST_SEP_SPACE,
		ST_OPEN,
		ST_READ,
		ST_DATA,
		ST_DUP,
		ST_CLOSE,
		ST_LINE
	} state_t;

	// What the accepted input byte was
	typedef enum logic [1:0] {
		K_BYTE,
		K_PIPE,
		K_LINE
	} kind_t;

	// One output byte offered by the sequencer
	typedef struct packed {
		logic       valid;
		logic [7:0] data;
		logic       last;
		logic       trunc;
	} emit_t;

endpackage

// ----- rtl/core/fce_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// Read data holds its value while no read is issued.
// No dependencies.
module fce_ram #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 28,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/core/fce_ctrl.sv -----
// Field sequencer: buffers field bytes into the field RAM and replays a
// finished field with quoting, separators and newline. Uses fce_pkg.
module fce_ctrl #(
	parameter int FIELD_BYTES = fce_pkg::FIELD_BYTES_DEF,
	parameter int AW = (FIELD_BYTES > 1) ? $clog2(FIELD_BYTES) : 1,
	parameter int LW = $clog2(FIELD_BYTES + 1)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [7:0]      in_byte,
	input  logic            out_free,
	output fce_pkg::emit_t  emit,
	output logic            ram_we,
	output logic [AW-1:0]   ram_waddr,
	output logic [7:0]      ram_wdata,
	output logic            ram_re,
	output logic [AW-1:0]   ram_raddr,
	input  logic [7:0]      ram_rdata
);

	import fce_pkg::*;

	state_t          state_q, state_d;
	kind_t           kind_q, kind_d;
	logic [LW-1:0]   len_q, len_d;
	logic [AW-1:0]   idx_q, idx_d;
	logic            quote_q, quote_d;
	logic            comma_q, comma_d;
	logic            sep_q, sep_d;
	logic            ovf_q, ovf_d;

	logic            wrap;
	logic            has_data;
	logic            last_idx;
	logic            go_field;
	logic            go_done;
	logic            advance;

	assign wrap     = quote_q | comma_q;
	assign has_data = (len_q != '0);
	assign last_idx = ((LW'(idx_q) + LW'(1)) == len_q);

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			kind_q  <= K_BYTE;
			len_q   <= '0;
			idx_q   <= '0;
			quote_q <= 1'b0;
			comma_q <= 1'b0;
			sep_q   <= 1'b0;
			ovf_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
			len_q   <= len_d;
			idx_q   <= idx_d;
			quote_q <= quote_d;
			comma_q <= comma_d;
			sep_q   <= sep_d;
			ovf_q   <= ovf_d;
		end
	end

	// Next state, RAM access and emitted byte
	always_comb begin
		state_d   = state_q;
		kind_d    = kind_q;
		len_d     = len_q;
		idx_d     = idx_q;
		quote_d   = quote_q;
		comma_d   = comma_q;
		sep_d     = sep_q;
		ovf_d     = ovf_q;
		emit      = '0;
		in_ready  = (state_q == ST_IDLE);
		ram_we    = 1'b0;
		ram_waddr = len_q[AW-1:0];
		ram_wdata = in_byte;
		ram_re    = 1'b0;
		ram_raddr = idx_q;
		go_field  = 1'b0;
		go_done   = 1'b0;
		advance   = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (in_byte == BYTE_PIPE) begin
						kind_d = K_PIPE;
						if (sep_q) begin
							sep_d   = 1'b0;
							state_d = ST_SEP_COMMA;
						end else begin
							go_field = 1'b1;
						end
					end else if (in_byte == BYTE_NEWLINE) begin
						kind_d = K_LINE;
						sep_d  = 1'b0;
						// trailing pipe: the empty last field is dropped
						if (sep_q) begin
							state_d = ST_LINE;
						end else begin
							go_field = 1'b1;
						end
					end else begin
						kind_d = K_BYTE;
						if (sep_q) begin
							sep_d   = 1'b0;
							state_d = ST_SEP_COMMA;
						end
						if (len_q < LW'(FIELD_BYTES)) begin
							ram_we = 1'b1;
							len_d  = len_q + LW'(1);
							if (in_byte == BYTE_QUOTE) begin
								quote_d = 1'b1;
							end
							if (in_byte == BYTE_COMMA) begin
								comma_d = 1'b1;
							end
						end else begin
							ovf_d = 1'b1;
						end
					end
				end
			end
			ST_SEP_COMMA: begin
				if (out_free) begin
					emit.valid = 1'b1;
					emit.data  = BYTE_COMMA;
					state_d    = ST_SEP_SPACE;
				end
			end
			ST_SEP_SPACE: begin
				if (out_free) begin
					emit.valid = 1'b1;
					emit.data  = BYTE_SPACE;
					emit.last  = (kind_q == K_BYTE) ||
						((kind_q == K_PIPE) && !wrap && !has_data);
					if (kind_q == K_BYTE) begin
						state_d = ST_IDLE;
					end else begin
						go_field = 1'b1;
					end
				end
			end
			ST_OPEN: begin
				if (out_free) begin
					emit.valid = 1'b1;
					emit.data  = BYTE_QUOTE;
					emit.trunc = ovf_q;
					idx_d      = '0;
					state_d    = has_data ? ST_READ : ST_CLOSE;
				end
			end
			ST_READ: begin
				ram_re  = 1'b1;
				state_d = ST_DATA;
			end
			ST_DATA: begin
				if (out_free) begin
					emit.valid = 1'b1;
					emit.data  = ram_rdata;
					emit.trunc = ovf_q;
					emit.last  = (kind_q == K_PIPE) && !wrap &&
						(ram_rdata != BYTE_QUOTE) && last_idx;
					if (ram_rdata == BYTE_QUOTE) begin
						state_d = ST_DUP;
					end else begin
						advance = 1'b1;
					end
				end
			end
			ST_DUP: begin
				if (out_free) begin
					emit.valid = 1'b1;
					emit.data  = BYTE_QUOTE;
					emit.trunc = ovf_q;
					emit.last  = (kind_q == K_PIPE) && !wrap && last_idx;
					advance    = 1'b1;
				end
			end
			ST_CLOSE: begin
				if (out_free) begin
					emit.valid = 1'b1;
					emit.data  = BYTE_QUOTE;
					emit.trunc = ovf_q;
					emit.last  = (kind_q == K_PIPE);
					go_done    = 1'b1;
				end
			end
			ST_LINE: begin
				if (out_free) begin
					emit.valid = 1'b1;
					emit.data  = BYTE_NEWLINE;
					emit.last  = 1'b1;
					len_d      = '0;
					quote_d    = 1'b0;
					comma_d    = 1'b0;
					ovf_d      = 1'b0;
					sep_d      = 1'b0;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// Step to next stored byte, or finish the field body
		if (advance) begin
			if (!last_idx) begin
				idx_d   = idx_q + AW'(1);
				state_d = ST_READ;
			end else if (wrap) begin
				state_d = ST_CLOSE;
			end else begin
				go_done = 1'b1;
			end
		end

		// Start of field replay
		if (go_field) begin
			if (wrap) begin
				state_d = ST_OPEN;
			end else if (has_data) begin
				idx_d   = '0;
				state_d = ST_READ;
			end else begin
				go_done = 1'b1;
			end
		end

		// Field finished: a pipe clears and arms the separator, a newline
		// goes on to emit the line end
		if (go_done) begin
			if (kind_d == K_PIPE) begin
				len_d   = '0;
				quote_d = 1'b0;
				comma_d = 1'b0;
				ovf_d   = 1'b0;
				sep_d   = 1'b1;
				state_d = ST_IDLE;
			end else begin
				state_d = ST_LINE;
			end
		end
	end

endmodule

// ----- rtl/core/pipe_to_csv_field_escaper.sv -----
// Top level of the pipe-to-CSV field escaper: field RAM, sequencer and
// output register. Depends on fce_pkg, fce_ram and fce_ctrl.
//
//  channel | dir | signals                         | beat
//  s_*     | in  | s_tvalid s_tready s_tdata[7:0]  | one text byte
//  m_*     | out | m_tvalid m_tready m_tdata[7:0]  | one CSV byte, m_tlast ends the run
//          |     | m_tlast m_tuser                 | of one input beat
//
// An ordinary byte is accepted in idle, then emits the ", " separator
// first if one is owed. A pipe or newline is accepted, then the field is
// replayed from the field RAM: each stored byte is read, then emitted, with
// an extra step per doubled quote and per framing byte (quotes, separator,
// newline); the single RAM read port sets this read-then-emit order.
// Reset is asynchronous and needs no clearing pass. A stalled m_tready holds
// the sequencer; the output register lets the next input beat be taken
// while the last result beat still waits.
module pipe_to_csv_field_escaper #(
	parameter int FIELD_BYTES = fce_pkg::FIELD_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic       m_tlast,
	output logic       m_tuser    // [0] truncated
);

	import fce_pkg::*;

	localparam int AW = (FIELD_BYTES > 1) ? $clog2(FIELD_BYTES) : 1;
	localparam int LW = $clog2(FIELD_BYTES + 1);

	emit_t         emit;
	logic          out_free;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0]    ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;

	logic          out_valid_q;
	logic [7:0]    out_data_q;
	logic          out_last_q;
	logic          out_trunc_q;

	fce_ram #(
		.DATA_W (8),
		.DEPTH  (FIELD_BYTES),
		.ADDR_W (AW)
	) u_field_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	fce_ctrl #(
		.FIELD_BYTES (FIELD_BYTES),
		.AW          (AW),
		.LW          (LW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_byte   (s_tdata),
		.out_free  (out_free),
		.emit      (emit),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	// Output register may load when empty or being drained
	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= emit.valid;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (out_free && emit.valid) begin
			out_data_q  <= emit.data;
			out_last_q  <= emit.last;
			out_trunc_q <= emit.trunc;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_trunc_q;

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for pipe_to_csv_field_escaper: streams pipe-delimited
// text in and checks every CSV beat against an in-bench escaper model.
// Depends on fce_pkg and the RTL of the block; reads no files.
module tb_top;
	import fce_pkg::*;

	localparam int FIELD_DEPTH  = 28;
	localparam int RANDOM_BYTES = 220;
	localparam int TAIL_BYTES   = 40;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 30;
	localparam int MAX_REPORTS  = 50;

	// One CSV beat as the block should produce it
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       trunc;
	} csv_beat_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = '0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic       m_tlast;
	logic       m_tuser;

	// Text still to be sent and CSV beats still owed by the block
	logic [7:0] text_q[$];
	csv_beat_t  csv_out_q[$];

	// Escaper model state
	logic [7:0] fld_buf[FIELD_DEPTH];
	int         fld_len;
	logic       fld_quote;
	logic       fld_comma;
	logic       fld_lost;
	logic       sep_owed;

	int err_count;
	int in_beats;
	int out_beats;
	int trunc_beats;
	int lines_seen;
	int cycles;
	int src_gap;
	int snk_gap;
	int phase_cnt;
	logic calm;
	logic tail;

	pipe_to_csv_field_escaper #(.FIELD_BYTES(FIELD_DEPTH)) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),    // [7:0] in_byte
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),    // [7:0] out_byte
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)     // [0] truncated
	);

	always #6 clk = ~clk;

	// ---------------- escaper model ----------------

	task automatic owe_beat(input logic [7:0] b, input logic tr, inout int n);
		csv_beat_t e;
		e.data  = b;
		e.last  = 1'b0;
		e.trunc = tr;
		csv_out_q.push_back(e);
		n++;
	endtask

	// Field replay: quotes doubled, wrapped once if it holds a quote or comma
	task automatic replay_field(inout int n);
		logic wrap;
		wrap = fld_quote || fld_comma;
		if (wrap)
			owe_beat(BYTE_QUOTE, fld_lost, n);
		for (int i = 0; i < fld_len; i++) begin
			owe_beat(fld_buf[i], fld_lost, n);
			if (fld_buf[i] == BYTE_QUOTE)
				owe_beat(BYTE_QUOTE, fld_lost, n);
		end
		if (wrap)
			owe_beat(BYTE_QUOTE, fld_lost, n);
	endtask

	task automatic owe_separator(inout int n);
		owe_beat(BYTE_COMMA, 1'b0, n);
		owe_beat(BYTE_SPACE, 1'b0, n);
		sep_owed = 1'b0;
	endtask

	task automatic start_field();
		fld_len   = 0;
		fld_quote = 1'b0;
		fld_comma = 1'b0;
		fld_lost  = 1'b0;
	endtask

	// Work out the CSV beats caused by one accepted text byte
	task automatic escape_byte(input logic [7:0] b);
		int n;
		csv_beat_t e;
		n = 0;
		if (b == BYTE_PIPE) begin
			if (sep_owed)
				owe_separator(n);
			replay_field(n);
			start_field();
			sep_owed = 1'b1;
		end else if (b == BYTE_NEWLINE) begin
			// a pipe right at the end of a line drops its empty field
			if (!sep_owed)
				replay_field(n);
			owe_beat(BYTE_NEWLINE, 1'b0, n);
			start_field();
			sep_owed = 1'b0;
			lines_seen++;
		end else begin
			if (sep_owed)
				owe_separator(n);
			if (fld_len < FIELD_DEPTH) begin
				fld_buf[fld_len] = b;
				fld_len++;
				if (b == BYTE_QUOTE)
					fld_quote = 1'b1;
				if (b == BYTE_COMMA)
					fld_comma = 1'b1;
			end else begin
				fld_lost = 1'b1;
			end
		end
		if (n > 0) begin
			e = csv_out_q[$];
			e.last = 1'b1;
			csv_out_q[$] = e;
		end
	endtask

	// ---------------- checking ----------------

	task automatic report_mismatch(input string what, input int got, input int want);
		if (err_count < MAX_REPORTS)
			$display("[%0t] mismatch on out beat %0d: %s got %0h want %0h",
				$realtime, out_beats, what, got, want);
		err_count++;
	endtask

	task automatic check_beat();
		csv_beat_t e;
		if (csv_out_q.size() == 0) begin
			report_mismatch("unexpected beat, data", m_tdata, 0);
		end else begin
			e = csv_out_q.pop_front();
			if (m_tdata !== e.data)
				report_mismatch("out_byte", m_tdata, e.data);
			if (m_tlast !== e.last)
				report_mismatch("last", m_tlast, e.last);
			if (m_tuser !== e.trunc)
				report_mismatch("truncated", m_tuser, e.trunc);
			if (e.trunc)
				trunc_beats++;
		end
		out_beats++;
	endtask

	// ---------------- stimulus helpers ----------------

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			text_q.push_back(s[i]);
	endtask

	// Field text, weighted toward quotes and commas
	function automatic logic [7:0] text_byte();
		logic [7:0] b;
		int r;
		r = $urandom_range(0, 9);
		if (r < 2) begin
			b = BYTE_QUOTE;
		end else if (r < 4) begin
			b = BYTE_COMMA;
		end else if (r < 7) begin
			b = 8'h61 + 8'($urandom_range(0, 25));
		end else begin
			do
				b = 8'($urandom_range(0, 255));
			while (b == BYTE_PIPE || b == BYTE_NEWLINE);
		end
		return b;
	endfunction

	// ---------------- clocked driver ----------------

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			src_gap  = 0;
		end else if (!s_tvalid || s_tready) begin
			if (src_gap > 0) begin
				src_gap = src_gap - 1;
				s_tvalid <= 1'b0;
			end else if (text_q.size() > 0 && !calm && !tail && $urandom_range(0, 3) == 0) begin
				// idle burst before the next byte
				src_gap = $urandom_range(0, 2);
				s_tvalid <= 1'b0;
			end else if (text_q.size() > 0) begin
				s_tdata  <= text_q.pop_front();
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Result-side backpressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			snk_gap  = 0;
		end else if (snk_gap > 0) begin
			snk_gap = snk_gap - 1;
			m_tready <= 1'b0;
		end else if (!calm && !tail && $urandom_range(0, 4) == 0) begin
			snk_gap = $urandom_range(0, 2);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Alternate stretches with and without idling; none near the end
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_cnt <= 30;
			calm      <= 1'b0;
			tail      <= 1'b0;
		end else begin
			tail <= (text_q.size() < TAIL_BYTES);
			if (phase_cnt == 0) begin
				calm      <= ~calm;
				phase_cnt <= $urandom_range(20, 80);
			end else begin
				phase_cnt <= phase_cnt - 1;
			end
		end
	end

	// ---------------- monitor ----------------

	always @(posedge clk) begin
		if (arst_n) begin
			// output beats belong to earlier input, so check first
			if (m_tvalid && m_tready)
				check_beat();
			if (s_tvalid && s_tready) begin
				escape_byte(s_tdata);
				in_beats++;
			end
		end
	end

	// Run watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d beats still owed",
				cycles, csv_out_q.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// ---------------- sequence ----------------

	initial begin
		int goal;
		int n_fields;
		int flen;

		err_count   = 0;
		in_beats    = 0;
		out_beats   = 0;
		trunc_beats = 0;
		lines_seen  = 0;
		cycles      = 0;
		sep_owed    = 1'b0;
		start_field();

		// Directed: empty line, quote+comma field, empty fields, edge bytes,
		// trailing pipe, leading pipe, quote doubling
		push_text("\n");
		push_text("\",|");
		text_q.push_back(BYTE_PIPE);
		text_q.push_back(8'h00);
		text_q.push_back(8'hFF);
		text_q.push_back(8'h0D);
		push_text("|\n");
		push_text("a\"b\n");
		push_text(",\n");
		push_text("|\n");
		push_text("\"\"|x\n");

		// Random lines, mostly well formed; some long fields overflow the buffer
		goal = RANDOM_BYTES;
		while (text_q.size() < goal) begin
			n_fields = $urandom_range(1, 5);
			for (int f = 0; f < n_fields; f++) begin
				if (f > 0)
					text_q.push_back(BYTE_PIPE);
				if ($urandom_range(0, 11) == 0)
					flen = $urandom_range(26, 33);
				else
					flen = $urandom_range(0, 6);
				for (int i = 0; i < flen; i++)
					text_q.push_back(text_byte());
				if ($urandom_range(0, 14) == 0)
					text_q.push_back(8'($urandom_range(0, 255)));
			end
			if ($urandom_range(0, 4) == 0)
				text_q.push_back(BYTE_PIPE);
			if ($urandom_range(0, 9) != 0)
				text_q.push_back(BYTE_NEWLINE);
		end
		text_q.push_back(BYTE_NEWLINE);

		// Reset once
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (text_q.size() > 0 || s_tvalid)
			@(posedge clk);
		while (csv_out_q.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d text bytes over %0d lines, checked %0d CSV beats",
			in_beats, lines_seen, out_beats);
		$display("%0d beats carried the truncated flag, %0d mismatches",
			trunc_beats, err_count);
		if (err_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
